[rtl/core/http2_frame_deframer_core_defines.svh]
// Assertion macros for the HTTP/2 deframer core.
// Included by the top level; no other dependencies.
`ifndef HTTP2_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define HTTP2_FRAME_DEFRAMER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define H2D_ASSERT_IMPL(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("h2d check failed");
`define H2D_ASSERT(lbl, prop) `H2D_ASSERT_IMPL(lbl, clk, arst_n, prop)
`else
`define H2D_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define H2D_ASSERT(lbl, prop)
`endif
`endif

[rtl/core/h2d_pkg.sv]
// Types and constants for the HTTP/2 deframer core.
// No dependencies.
package h2d_pkg;
	typedef enum logic [8:0] {
		PH_HDR  = 9'b000000001,
		PH_SKIP = 9'b000000010,
		PH_SET  = 9'b000000100,
		PH_WIN  = 9'b000001000,
		PH_GOA  = 9'b000010000,
		PH_GDBG = 9'b000100000,
		PH_PAD  = 9'b001000000,
		PH_PRIO = 9'b010000000,
		PH_BODY = 9'b100000000
	} phase_t;

	localparam logic [2:0] K_HDR = 3'd0, K_PRIO = 3'd1, K_SET = 3'd2, K_WIN = 3'd3,
		K_GOA = 3'd4, K_BYTE = 3'd5, K_END = 3'd6;
	localparam logic [2:0] ST_OK = 3'd0, ST_SKIP = 3'd1, ST_INV = 3'd2, ST_LEN = 3'd3,
		ST_ACK = 3'd4, ST_PAD = 3'd5, ST_TRUNC = 3'd6;
	localparam logic [7:0] T_DATA = 8'd0, T_HEADERS = 8'd1, T_SETTINGS = 8'd4,
		T_GOAWAY = 8'd7, T_WINDOW = 8'd8, TYPE_LIMIT = 8'd13;
	localparam int FL_ACK = 0, FL_PADDED = 3, FL_PRIORITY = 5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  frame_type;
		logic [7:0]  frame_flags;
		logic [30:0] stream_id;
		logic [23:0] frame_length;
		logic [31:0] word_a;
		logic [31:0] word_b;
		logic        exclusive_bit;
		logic [7:0]  payload_byte;
		logic        frame_end;
		logic [2:0]  status;
	} result_t;
endpackage

[rtl/core/h2d_parser.sv]
// Byte-step parser of the HTTP/2 deframer: frame state and result decode.
// Depends on h2d_pkg.
module h2d_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        in_byte,
	output logic              res_valid,
	output h2d_pkg::result_t  res
);
	h2d_pkg::phase_t ph_q, ph_d;
	logic [3:0]  hidx_q, hidx_d;
	logic [23:0] len_q, len_d, left_q, left_d, left_dec;
	logic [7:0]  type_q, type_d, flags_q, flags_d, pad_q, pad_d;
	logic [30:0] strm_q, strm_d;
	logic [47:0] sh_q, sh_d, sh_n;
	logic [2:0]  fidx_q, fidx_d, err_q, err_d;
	logic [31:0] held_q, held_d;

	logic        prio, padded, last, emit;
	logic [23:0] need, avail;
	logic [2:0]  kind;
	logic [31:0] wa, wb;
	logic        ex;
	logic [7:0]  pb;

	// residue mod 3 from the sum of base-4 digits
	function automatic logic [1:0] mod3(input logic [23:0] v);
		logic [5:0] s;
		logic [3:0] t;
		s = '0;
		for (int i = 0; i < 12; i++) s = s + {4'd0, v[2 * i +: 2]};
		t = {2'd0, s[1:0]} + {2'd0, s[3:2]} + {2'd0, s[5:4]};
		if (t >= 4'd6) t = t - 4'd6;
		if (t >= 4'd3) t = t - 4'd3;
		return t[1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= h2d_pkg::PH_HDR; hidx_q <= '0; len_q <= '0; left_q <= '0;
			type_q <= '0; flags_q <= '0; pad_q <= '0; strm_q <= '0; sh_q <= '0;
			fidx_q <= '0; err_q <= '0; held_q <= '0;
		end else if (step) begin
			ph_q <= ph_d; hidx_q <= hidx_d; len_q <= len_d; left_q <= left_d;
			type_q <= type_d; flags_q <= flags_d; pad_q <= pad_d; strm_q <= strm_d;
			sh_q <= sh_d; fidx_q <= fidx_d; err_q <= err_d; held_q <= held_d;
		end
	end

	always_comb begin
		ph_d = ph_q; hidx_d = hidx_q; len_d = len_q; left_d = left_q;
		type_d = type_q; flags_d = flags_q; pad_d = pad_q; strm_d = strm_q;
		sh_d = sh_q; fidx_d = fidx_q; err_d = err_q; held_d = held_q;
		emit = 1'b0; kind = h2d_pkg::K_HDR; wa = '0; wb = '0; ex = 1'b0; pb = '0;
		last = 1'b0;
		sh_n = {sh_q[39:0], in_byte};
		left_dec = (left_q != 24'd0) ? left_q - 24'd1 : 24'd0;
		prio = (type_q == h2d_pkg::T_HEADERS) && flags_q[h2d_pkg::FL_PRIORITY];
		padded = flags_q[h2d_pkg::FL_PADDED];
		need = {21'd0, prio, 1'b0, prio} + {23'd0, padded};
		avail = (left_dec >= {21'd0, prio, 1'b0, prio}) ?
			left_dec - {21'd0, prio, 1'b0, prio} : 24'd0;
		if (ph_q == h2d_pkg::PH_HDR) begin
			if (hidx_q < 4'd3) len_d = {len_q[15:0], in_byte};
			else if (hidx_q == 4'd3) type_d = in_byte;
			else if (hidx_q == 4'd4) flags_d = in_byte;
			else strm_d = {strm_q[22:0], in_byte};
			hidx_d = hidx_q + 4'd1;
			if (hidx_q == 4'd8) begin
				hidx_d = '0; left_d = len_q; pad_d = '0; sh_d = '0; fidx_d = '0;
				held_d = '0; emit = 1'b1; kind = h2d_pkg::K_HDR;
				last = (len_q == 24'd0);
				err_d = h2d_pkg::ST_OK; ph_d = h2d_pkg::PH_SKIP;
				if (type_q >= h2d_pkg::TYPE_LIMIT) err_d = h2d_pkg::ST_INV;
				else if (type_q == h2d_pkg::T_SETTINGS) begin
					if (len_q[0] || mod3(len_q) != 2'd0) err_d = h2d_pkg::ST_LEN;
					else if (flags_q[h2d_pkg::FL_ACK] && len_q != 24'd0)
						err_d = h2d_pkg::ST_ACK;
					else ph_d = h2d_pkg::PH_SET;
				end else if (type_q == h2d_pkg::T_WINDOW) begin
					if (len_q != 24'd4) err_d = h2d_pkg::ST_LEN;
					else ph_d = h2d_pkg::PH_WIN;
				end else if (type_q == h2d_pkg::T_GOAWAY) begin
					if (len_q < 24'd8) err_d = h2d_pkg::ST_LEN;
					else ph_d = h2d_pkg::PH_GOA;
				end else if (type_q == h2d_pkg::T_DATA || type_q == h2d_pkg::T_HEADERS) begin
					if (len_q < need) err_d = h2d_pkg::ST_TRUNC;
					else if (padded) ph_d = h2d_pkg::PH_PAD;
					else if (prio) ph_d = h2d_pkg::PH_PRIO;
					else ph_d = h2d_pkg::PH_BODY;
				end else err_d = h2d_pkg::ST_SKIP;
				if (last) ph_d = h2d_pkg::PH_HDR;
			end
		end else begin
			left_d = left_dec;
			last = (left_dec == 24'd0);
			case (ph_q)
				h2d_pkg::PH_SET: begin
					sh_d = sh_n;
					if (fidx_q >= 3'd5) begin
						emit = 1'b1; kind = h2d_pkg::K_SET; wa = sh_n[31:0];
						wb = {16'd0, sh_n[47:32]}; fidx_d = '0; sh_d = '0;
					end else fidx_d = fidx_q + 3'd1;
				end
				h2d_pkg::PH_WIN: begin
					sh_d = sh_n;
					if (fidx_q >= 3'd3) begin
						emit = 1'b1; kind = h2d_pkg::K_WIN; wa = {1'b0, sh_n[30:0]};
						fidx_d = '0;
					end else fidx_d = fidx_q + 3'd1;
				end
				h2d_pkg::PH_GOA: begin
					sh_d = sh_n;
					if (fidx_q == 3'd3) held_d = sh_n[31:0];
					if (fidx_q >= 3'd7) begin
						emit = 1'b1; kind = h2d_pkg::K_GOA; wa = held_q; wb = sh_n[31:0];
						fidx_d = '0; ph_d = h2d_pkg::PH_GDBG;
					end else fidx_d = fidx_q + 3'd1;
				end
				h2d_pkg::PH_GDBG: begin
					emit = 1'b1; kind = h2d_pkg::K_BYTE; pb = in_byte;
				end
				h2d_pkg::PH_PAD: begin
					pad_d = in_byte;
					if ({16'd0, in_byte} > avail) begin
						err_d = h2d_pkg::ST_PAD; ph_d = h2d_pkg::PH_SKIP;
					end else ph_d = prio ? h2d_pkg::PH_PRIO : h2d_pkg::PH_BODY;
				end
				h2d_pkg::PH_PRIO: begin
					sh_d = sh_n;
					if (fidx_q >= 3'd4) begin
						emit = 1'b1; kind = h2d_pkg::K_PRIO; wa = {1'b0, sh_n[38:8]};
						wb = {24'd0, sh_n[7:0]}; ex = sh_n[39]; fidx_d = '0;
						ph_d = h2d_pkg::PH_BODY;
					end else fidx_d = fidx_q + 3'd1;
				end
				h2d_pkg::PH_BODY: begin
					if (left_dec >= {16'd0, pad_q}) begin
						emit = 1'b1; kind = h2d_pkg::K_BYTE; pb = in_byte;
					end
				end
				default: ;
			endcase
			if (last) begin
				ph_d = h2d_pkg::PH_HDR;
				if (!emit) begin
					emit = 1'b1; kind = h2d_pkg::K_END;
				end
			end
		end
		res_valid = emit;
		res.kind = kind;
		res.frame_type = type_d;
		res.frame_flags = flags_d;
		res.stream_id = strm_d;
		res.frame_length = len_d;
		res.word_a = wa;
		res.word_b = wb;
		res.exclusive_bit = ex;
		res.payload_byte = pb;
		res.frame_end = last;
		res.status = err_d;
	end
endmodule

[rtl/core/http2_frame_deframer_core.sv]
// HTTP/2 frame deframer core: one byte per cycle, zero or one result per byte.
// The result is registered: it is valid in the cycle after its byte's transaction.
// Throughput: one byte per cycle while the result register is not held by out_stall.
// Reset: asynchronous, active low; clears parser state and the result valid flag.
// Depends on h2d_pkg, h2d_parser and http2_frame_deframer_core_defines.svh.
`include "http2_frame_deframer_core_defines.svh"
module http2_frame_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  frame_type,
	output logic [7:0]  frame_flags,
	output logic [30:0] stream_id,
	output logic [23:0] frame_length,
	output logic [31:0] word_a,
	output logic [31:0] word_b,
	output logic        exclusive_bit,
	output logic [7:0]  payload_byte,
	output logic        frame_end,
	output logic [2:0]  status
);
	logic step, res_valid;
	h2d_pkg::result_t res, out_q;
	logic ov_q;

	assign in_stall = ov_q && out_stall;
	assign step = in_valid && !in_stall;

	h2d_parser u_parser (
		.clk(clk), .arst_n(arst_n), .step(step), .in_byte(in_byte),
		.res_valid(res_valid), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (!in_stall) ov_q <= step && res_valid;
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) out_q <= res;
	end

	assign out_valid = ov_q;
	assign kind = out_q.kind;
	assign frame_type = out_q.frame_type;
	assign frame_flags = out_q.frame_flags;
	assign stream_id = out_q.stream_id;
	assign frame_length = out_q.frame_length;
	assign word_a = out_q.word_a;
	assign word_b = out_q.word_b;
	assign exclusive_bit = out_q.exclusive_bit;
	assign payload_byte = out_q.payload_byte;
	assign frame_end = out_q.frame_end;
	assign status = out_q.status;

	`H2D_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_q))
	`H2D_ASSERT(a_nostep, out_valid && out_stall |-> !step)
	`H2D_ASSERT(a_endkind, out_valid && kind == h2d_pkg::K_END |-> frame_end)
endmodule
